/* rtl/fbfs_pkg.sv */
// ----------------------------------------------------------------------------
// fbfs_pkg
// Shared types and constants for the frame store fill and scaled scan-out
// unit: request and response payloads, request kinds, sequencer states.
// ----------------------------------------------------------------------------
package fbfs_pkg;

   // Field widths fixed by the interface
   localparam int COORD_W = 9;
   localparam int COLOR_W = 16;

   localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   // Request kinds; the fourth code is unused and ignored
   typedef enum logic [1:0] {
      KIND_DRAW = 2'd0,
      KIND_FILL = 2'd1,
      KIND_SCAN = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] rect_width;
      logic [COORD_W-1:0] rect_height;
      logic [COLOR_W-1:0] color;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [COLOR_W-1:0] pixel_out;
      logic               pixel_valid;
      logic               end_of_line;
      logic               end_of_frame;
   } rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_FILL,
      ST_FINISH
   } state_type;

endpackage

/* rtl/framebuffer_fill_and_scaled_scanout_unit.sv */
// ----------------------------------------------------------------------------
// framebuffer_fill_and_scaled_scanout_unit
// RGB565 logical frame store with pixel draw, clipped rectangle fill and
// scan-out that repeats each logical pixel PIXEL_SCALE times both ways.
//
// Usage:
//   req_*  : valid/ready request channel (draw, fill or scan tick).
//   rsp_*  : valid/ready response channel, one response per request.
//   csr_*  : orientation write (landscape bit); always ready, and a write
//            restarts the scan at the top left pixel.
// Operation:
//   After reset the store is swept to black, one entry per cycle, over all
//   (NATIVE_WIDTH/PIXEL_SCALE)*(NATIVE_HEIGHT/PIXEL_SCALE) entries (19200 by
//   default); requests wait until the sweep ends, csr writes are taken.
//   Scan tick: the response follows the registered store read.
//   Draw and fill: a setup state, then one store write per covered pixel
//   through the single write port. Ignored requests go straight to finish.
//   The response is registered in an output register; a stalled receiver
//   holds it there while a new request can still be taken, but the
//   sequencer then waits in its finish state with the next result.
// ----------------------------------------------------------------------------
module framebuffer_fill_and_scaled_scanout_unit #(
   parameter int NATIVE_WIDTH  = 240,
   parameter int NATIVE_HEIGHT = 320,
   parameter int PIXEL_SCALE   = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fbfs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fbfs_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import fbfs_pkg::*;

   localparam int DEPTH = (NATIVE_WIDTH / PIXEL_SCALE) * (NATIVE_HEIGHT / PIXEL_SCALE);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic               res_valid, res_ready;
   rsp_type            res_payload;
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [COLOR_W-1:0] wr_data, rd_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;

   assign csr_ready = 1'b1;

   fbfs_ctrl #(
      .NATIVE_WIDTH  (NATIVE_WIDTH),
      .NATIVE_HEIGHT (NATIVE_HEIGHT),
      .PIXEL_SCALE   (PIXEL_SCALE),
      .DEPTH         (DEPTH),
      .AW            (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   fbfs_frame_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: loads when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res_payload;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* rtl/fbfs_frame_ram.sv */
// ----------------------------------------------------------------------------
// fbfs_frame_ram
// Logical frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbfs_frame_ram #(
   parameter int DEPTH = 19200,
   parameter int AW    = 15
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [fbfs_pkg::COLOR_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [fbfs_pkg::COLOR_W-1:0] rd_data
);
   import fbfs_pkg::*;

   logic [COLOR_W-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/fbfs_ctrl.sv */
// ----------------------------------------------------------------------------
// fbfs_ctrl
// Sequencer: clears the store after reset, walks draw and fill rectangles
// one pixel per cycle, and keeps the scan position for scan ticks.
// ----------------------------------------------------------------------------
module fbfs_ctrl #(
   parameter int NATIVE_WIDTH  = 240,
   parameter int NATIVE_HEIGHT = 320,
   parameter int PIXEL_SCALE   = 2,
   parameter int DEPTH         = 19200,
   parameter int AW            = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  fbfs_pkg::req_type            req_payload,
   input  logic                         csr_valid,
   input  logic                         csr_data,
   output logic                         res_valid,
   input  logic                         res_ready,
   output fbfs_pkg::rsp_type            res_payload,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic [fbfs_pkg::COLOR_W-1:0] wr_data,
   output logic                         rd_en,
   output logic [AW-1:0]                rd_addr,
   input  logic [fbfs_pkg::COLOR_W-1:0] rd_data
);
   import fbfs_pkg::*;

   localparam int EXT_W = COORD_W + 1;
   localparam int SUM_W = 2 * COORD_W;
   localparam int SUB_W = (PIXEL_SCALE > 1) ? $clog2(PIXEL_SCALE) : 1;
   localparam logic [COORD_W-1:0] LW_PORTRAIT  = COORD_W'(NATIVE_WIDTH / PIXEL_SCALE);
   localparam logic [COORD_W-1:0] LH_PORTRAIT  = COORD_W'(NATIVE_HEIGHT / PIXEL_SCALE);
   localparam logic [SUB_W-1:0]   SUB_LAST     = SUB_W'(PIXEL_SCALE - 1);
   localparam logic [AW-1:0]      ADDR_LAST    = AW'(DEPTH - 1);

   state_type state_ff, state_in;
   logic landscape_ff, landscape_in;

   // Rectangle walk
   logic [COORD_W-1:0] px_ff, px_in;
   logic [COORD_W-1:0] ex_ff, ex_in;
   logic [COORD_W-1:0] ey_ff, ey_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [AW-1:0]      row_base_ff, row_base_in;
   logic [COLOR_W-1:0] color_ff, color_in;

   // Result fields
   logic status_ff, status_in;
   logic is_scan_ff, is_scan_in;
   logic eol_ff, eol_in;
   logic eof_ff, eof_in;

   // Clear sweep
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // Scan position: logical column/row plus repeat counters
   logic [COORD_W-1:0] scan_col_ff, scan_col_in;
   logic [SUB_W-1:0]   scan_subx_ff, scan_subx_in;
   logic [COORD_W-1:0] scan_row_ff, scan_row_in;
   logic [SUB_W-1:0]   scan_suby_ff, scan_suby_in;
   logic [AW-1:0]      scan_base_ff, scan_base_in;

   logic [COORD_W-1:0] lw, lh;
   logic               req_fire;
   logic               rect_ok;
   logic [EXT_W-1:0]   sum_x, sum_y;
   logic [COORD_W-1:0] clip_x, clip_y;
   logic               last_col, last_row;
   logic [SUM_W-1:0]   row_prod;
   logic               scan_eol, scan_eof;

   // Logical size follows orientation
   always_comb begin
      lw = landscape_ff ? LH_PORTRAIT : LW_PORTRAIT;
      lh = landscape_ff ? LW_PORTRAIT : LH_PORTRAIT;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign res_valid = (state_ff == ST_FINISH);

   // Request decode: clipping and validity
   always_comb begin
      sum_x  = EXT_W'(req_payload.pos_x) + EXT_W'(req_payload.rect_width);
      sum_y  = EXT_W'(req_payload.pos_y) + EXT_W'(req_payload.rect_height);
      clip_x = (sum_x > EXT_W'(lw)) ? lw : sum_x[COORD_W-1:0];
      clip_y = (sum_y > EXT_W'(lh)) ? lh : sum_y[COORD_W-1:0];
      rect_ok = (req_payload.pos_x < lw) && (req_payload.pos_y < lh);
   end

   // Rectangle walk end tests and row base product
   always_comb begin
      last_col = (EXT_W'(col_ff) + EXT_W'(1)) == EXT_W'(ex_ff);
      last_row = (EXT_W'(row_ff) + EXT_W'(1)) == EXT_W'(ey_ff);
      row_prod = SUM_W'(row_ff) * SUM_W'(lw);
   end

   // Scan line and frame ends
   always_comb begin
      scan_eol = (scan_col_ff == lw - COORD_W'(1)) && (scan_subx_ff == SUB_LAST);
      scan_eof = scan_eol && (scan_row_ff == lh - COORD_W'(1))
                 && (scan_suby_ff == SUB_LAST);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_payload.kind)
                  KIND_DRAW: state_in = rect_ok ? ST_SETUP : ST_FINISH;
                  KIND_FILL: begin
                     state_in = (rect_ok && req_payload.rect_width != '0
                                 && req_payload.rect_height != '0) ? ST_SETUP : ST_FINISH;
                  end
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_SETUP:  state_in = ST_FILL;
         ST_FILL: begin
            if (last_col && last_row) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory port control
   always_comb begin
      landscape_in = landscape_ff;
      px_in        = px_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      row_base_in  = row_base_ff;
      color_in     = color_ff;
      status_in    = status_ff;
      is_scan_in   = is_scan_ff;
      eol_in       = eol_ff;
      eof_in       = eof_ff;
      clr_addr_in  = clr_addr_ff;
      scan_col_in  = scan_col_ff;
      scan_subx_in = scan_subx_ff;
      scan_row_in  = scan_row_ff;
      scan_suby_in = scan_suby_ff;
      scan_base_in = scan_base_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(SUM_W'(row_base_ff) + SUM_W'(col_ff));
      wr_data      = color_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(SUM_W'(scan_base_ff) + SUM_W'(scan_col_ff));

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = COLOR_BLACK;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               px_in      = req_payload.pos_x;
               col_in     = req_payload.pos_x;
               row_in     = req_payload.pos_y;
               color_in   = req_payload.color;
               status_in  = STATUS_IGNORED;
               is_scan_in = 1'b0;
               eol_in     = 1'b0;
               eof_in     = 1'b0;
               case (req_payload.kind)
                  KIND_DRAW: begin
                     // A draw is a one by one rectangle
                     ex_in = req_payload.pos_x + COORD_W'(1);
                     ey_in = req_payload.pos_y + COORD_W'(1);
                     if (rect_ok) status_in = STATUS_DONE;
                  end
                  KIND_FILL: begin
                     ex_in = clip_x;
                     ey_in = clip_y;
                     if (rect_ok && req_payload.rect_width != '0
                         && req_payload.rect_height != '0) status_in = STATUS_DONE;
                  end
                  KIND_SCAN: begin
                     rd_en      = 1'b1;
                     status_in  = STATUS_DONE;
                     is_scan_in = 1'b1;
                     eol_in     = scan_eol;
                     eof_in     = scan_eof;
                     // Advance the physical scan position
                     if (scan_eol) begin
                        scan_col_in  = '0;
                        scan_subx_in = '0;
                        if (scan_suby_ff == SUB_LAST) begin
                           scan_suby_in = '0;
                           if (scan_eof) begin
                              scan_row_in  = '0;
                              scan_base_in = '0;
                           end else begin
                              scan_row_in  = scan_row_ff + COORD_W'(1);
                              scan_base_in = AW'(SUM_W'(scan_base_ff) + SUM_W'(lw));
                           end
                        end else begin
                           scan_suby_in = scan_suby_ff + SUB_W'(1);
                        end
                     end else if (scan_subx_ff == SUB_LAST) begin
                        scan_subx_in = '0;
                        scan_col_in  = scan_col_ff + COORD_W'(1);
                     end else begin
                        scan_subx_in = scan_subx_ff + SUB_W'(1);
                     end
                  end
                  default: begin
                     ex_in = ex_ff;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            row_base_in = AW'(row_prod);
         end
         ST_FILL: begin
            wr_en = 1'b1;
            if (last_col) begin
               col_in      = px_ff;
               row_in      = row_ff + COORD_W'(1);
               row_base_in = AW'(SUM_W'(row_base_ff) + SUM_W'(lw));
            end else begin
               col_in = col_ff + COORD_W'(1);
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase

      // Orientation write restarts the scan
      if (csr_valid) begin
         landscape_in = csr_data;
         scan_col_in  = '0;
         scan_subx_in = '0;
         scan_row_in  = '0;
         scan_suby_in = '0;
         scan_base_in = '0;
      end
   end

   // Result presented from the finish state
   always_comb begin
      res_payload.status       = status_ff;
      res_payload.pixel_out    = is_scan_ff ? rd_data : COLOR_BLACK;
      res_payload.pixel_valid  = is_scan_ff;
      res_payload.end_of_line  = eol_ff;
      res_payload.end_of_frame = eof_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         landscape_ff <= 1'b1;
         clr_addr_ff  <= '0;
         scan_col_ff  <= '0;
         scan_subx_ff <= '0;
         scan_row_ff  <= '0;
         scan_suby_ff <= '0;
         scan_base_ff <= '0;
      end else begin
         state_ff     <= state_in;
         landscape_ff <= landscape_in;
         clr_addr_ff  <= clr_addr_in;
         scan_col_ff  <= scan_col_in;
         scan_subx_ff <= scan_subx_in;
         scan_row_ff  <= scan_row_in;
         scan_suby_ff <= scan_suby_in;
         scan_base_ff <= scan_base_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      row_base_ff <= row_base_in;
      color_ff    <= color_in;
      status_ff   <= status_in;
      is_scan_ff  <= is_scan_in;
      eol_ff      <= eol_in;
      eof_ff      <= eof_in;
   end

endmodule
